>>> rtl/gsfe_pkg.sv
// Shared types, codes and constant tables of the gas sensor frame exchange.
package gsfe_pkg;

   localparam int FRAME_LEN = 9;
   localparam int KEPT_BYTES = 6;
   localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
   localparam int KEPT_IDX_W = $clog2(KEPT_BYTES);
   localparam logic [FRAME_IDX_W-1:0] LAST_IDX = FRAME_IDX_W'(FRAME_LEN - 1);

   localparam logic [7:0] TIMEOUT_RESET = 8'd100;
   localparam logic [8:0] ELAPSED_MAX = 9'd511;
   localparam logic [7:0] HDR_START = 8'hFF;
   localparam logic [7:0] HDR_CMD = 8'h9C;
   localparam logic [7:0] SUM_GOOD = 8'hFF;

   typedef enum logic [2:0] {
      CMD_POLL     = 3'd0,
      CMD_ZERO_CAL = 3'd1,
      CMD_RX_BYTE  = 3'd2,
      CMD_TICK     = 3'd3,
      CMD_READ     = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_TX_BYTE = 3'd0,
      KIND_ACCEPT  = 3'd1,
      KIND_REJECT  = 3'd2,
      KIND_TIMEOUT = 3'd3,
      KIND_READ    = 3'd4
   } kind_type;

   typedef enum logic {
      SEL_PPM     = 1'b0,
      SEL_PERCENT = 1'b1
   } read_sel_type;

   typedef enum logic {
      REQ_MEASURE = 1'b0,
      REQ_ZERO    = 1'b1
   } frame_sel_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] rx_byte;
      logic       read_select;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [31:0] reading_ppm;
      logic [25:0] percent_hundredths;
      logic        value_valid;
   } rsp_type;

   localparam logic [7:0] MEASURE_REQ [FRAME_LEN] =
      '{8'hFF, 8'h01, 8'h9C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h63};
   localparam logic [7:0] ZERO_REQ [FRAME_LEN] =
      '{8'hFF, 8'h01, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h78};

   // One outgoing request byte as a result transaction.
   function automatic rsp_type tx_result(frame_sel_type sel, logic [FRAME_IDX_W-1:0] idx);
      rsp_type r;
      r = '0;
      r.kind = KIND_TX_BYTE;
      r.tx_byte = (sel == REQ_ZERO) ? ZERO_REQ[idx] : MEASURE_REQ[idx];
      r.last = (idx == LAST_IDX);
      return r;
   endfunction

endpackage

>>> rtl/gsfe_pct_div.sv
// Two-stage divide of the frame reading by 100 (reciprocal multiply, one correction).
module gsfe_pct_div
   import gsfe_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] value,
   output logic [25:0] percent
);

   // v/100 == (v>>2)/25; recip = floor(2^32/25) keeps q0 within one of the quotient
   localparam logic [27:0] RECIP_25 = 28'd171798691;
   localparam logic [30:0] DIV_25 = 31'd25;

   logic [29:0] quarter;
   logic [57:0] product;
   logic [25:0] q0_ff;
   logic [29:0] quarter_ff;
   logic [30:0] q0_x25;
   logic [30:0] remainder;
   logic [25:0] percent_ff;
   logic [25:0] percent_in;

   assign quarter = value[31:2];
   assign product = 58'(quarter) * 58'(RECIP_25);

   always_ff @(posedge clock) begin
      q0_ff <= product[57:32];
      quarter_ff <= quarter;
   end

   always_comb begin
      q0_x25 = (31'(q0_ff) << 4) + (31'(q0_ff) << 3) + 31'(q0_ff);
      remainder = 31'(quarter_ff) - q0_x25;
      percent_in = (remainder >= DIV_25) ? q0_ff + 26'd1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      percent_ff <= percent_in;
   end

   assign percent = percent_ff;

endmodule

>>> rtl/gas_sensor_frame_exchange_top.sv
// Top level of the gas sensor frame exchange: command decode, reply checker, result register.
//
// Request/reply engine for a nine-byte UART gas sensor.
// Input channel (req_valid/req_ready/req_data): one transaction per command:
//   measure, zero calibrate, received byte, millisecond tick or read.
// Result channel (rsp_valid/rsp_ready/rsp_data): measure and calibrate give
//   nine byte-to-send transactions, last set on the ninth; a completed reply
//   gives one accepted or rejected transaction; an expired reply one timeout;
//   a read one read reply. Bytes and ticks that find no reply pending, and
//   unused command codes, give nothing.
// Timing: a command is decoded in the cycle it is accepted; its first result
//   is registered and on rsp_data from the next cycle.
// Throughput: one transaction per cycle for single-result commands while the
//   receiver takes each result. A request frame holds req_ready low until its
//   ninth byte is taken (the single result register is the limit).
// Percent value: two-stage divider over the stored reply bytes (q0_ff, then percent_ff).
// csr_wr_en/csr_wr_data write timeout_ms (reset 100); write only while idle.
// Reset (synchronous, active high) drops any pending reply, result and stored
//   reading. A stalled receiver holds the result; input is taken again as soon
//   as the result register is free or being emptied.
module gas_sensor_frame_exchange_top
   import gsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   // configuration
   logic [7:0] timeout_ff;

   // reply collection
   logic                   phase_ff, phase_in;
   logic [FRAME_IDX_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]             sum_ff, sum_in;
   logic [8:0]             elapsed_ff, elapsed_in;
   logic [7:0]             frame_ff [KEPT_BYTES];
   logic                   fb_wr_en;
   logic [KEPT_IDX_W-1:0]  fb_wr_idx;

   // stored values
   logic [31:0] ppm_ff, ppm_in;
   logic        ppm_present_ff, ppm_present_in;
   logic [25:0] pct_ff, pct_in;
   logic        pct_present_ff, pct_present_in;

   // request frame sender
   logic                   send_active_ff, send_active_in;
   logic [FRAME_IDX_W-1:0] send_idx_ff, send_idx_in;
   frame_sel_type          send_sel_ff, send_sel_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic        req_accept;
   logic        rsp_take;
   logic [31:0] frame_value;
   logic [25:0] frame_pct;
   logic [7:0]  sum_next;
   logic [8:0]  elapsed_next;

   assign frame_value = {frame_ff[2], frame_ff[3], frame_ff[4], frame_ff[5]};

   gsfe_pct_div u_pct_div (
      .clock   (clock),
      .value   (frame_value),
      .percent (frame_pct)
   );

   assign rsp_take = rsp_valid_ff && rsp_ready;
   // blocked while a result waits untaken or a request frame has bytes after the current one
   assign req_ready = (!rsp_valid_ff || rsp_ready) &&
                      !(send_active_ff && (send_idx_ff != LAST_IDX));
   assign req_accept = req_valid && req_ready;

   assign sum_next = sum_ff + req_data.rx_byte;
   assign elapsed_next = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 9'd1 : elapsed_ff;

   always_comb begin
      phase_in = phase_ff;
      byte_count_in = byte_count_ff;
      sum_in = sum_ff;
      elapsed_in = elapsed_ff;
      ppm_in = ppm_ff;
      ppm_present_in = ppm_present_ff;
      pct_in = pct_ff;
      pct_present_in = pct_present_ff;
      send_active_in = send_active_ff;
      send_idx_in = send_idx_ff;
      send_sel_in = send_sel_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fb_wr_en = 1'b0;
      fb_wr_idx = byte_count_ff[KEPT_IDX_W-1:0];

      // advance the frame sender as each byte is taken
      if (send_active_ff && rsp_take) begin
         if (send_idx_ff != LAST_IDX) begin
            send_idx_in = send_idx_ff + 1'b1;
            rsp_in = tx_result(send_sel_ff, send_idx_ff + 1'b1);
            rsp_valid_in = 1'b1;
         end else begin
            send_active_in = 1'b0;
         end
      end

      if (req_accept) begin
         unique case (req_data.command)
            CMD_POLL: begin
               ppm_in = '0;
               ppm_present_in = 1'b0;
               phase_in = 1'b1;
               byte_count_in = '0;
               sum_in = '0;
               elapsed_in = '0;
               send_active_in = 1'b1;
               send_idx_in = '0;
               send_sel_in = REQ_MEASURE;
               rsp_in = tx_result(REQ_MEASURE, '0);
               rsp_valid_in = 1'b1;
            end
            CMD_ZERO_CAL: begin
               send_active_in = 1'b1;
               send_idx_in = '0;
               send_sel_in = REQ_ZERO;
               rsp_in = tx_result(REQ_ZERO, '0);
               rsp_valid_in = 1'b1;
            end
            CMD_RX_BYTE: begin
               if (phase_ff) begin
                  fb_wr_en = (byte_count_ff < FRAME_IDX_W'(KEPT_BYTES));
                  if (byte_count_ff != LAST_IDX) begin
                     byte_count_in = byte_count_ff + 1'b1;
                     sum_in = sum_next;
                  end else begin
                     // ninth byte: header and checksum decide
                     phase_in = 1'b0;
                     byte_count_in = '0;
                     sum_in = '0;
                     rsp_in = '0;
                     rsp_in.last = 1'b1;
                     rsp_valid_in = 1'b1;
                     if (frame_ff[0] == HDR_START && frame_ff[1] == HDR_CMD &&
                         sum_next == SUM_GOOD) begin
                        ppm_in = frame_value;
                        ppm_present_in = 1'b1;
                        pct_in = frame_pct;
                        pct_present_in = 1'b1;
                        rsp_in.kind = KIND_ACCEPT;
                        rsp_in.reading_ppm = frame_value;
                        rsp_in.percent_hundredths = frame_pct;
                        rsp_in.value_valid = 1'b1;
                     end else begin
                        rsp_in.kind = KIND_REJECT;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (phase_ff) begin
                  if (elapsed_next > {1'b0, timeout_ff}) begin
                     phase_in = 1'b0;
                     byte_count_in = '0;
                     sum_in = '0;
                     elapsed_in = '0;
                     rsp_in = '0;
                     rsp_in.kind = KIND_TIMEOUT;
                     rsp_in.last = 1'b1;
                     rsp_valid_in = 1'b1;
                  end else begin
                     elapsed_in = elapsed_next;
                  end
               end
            end
            CMD_READ: begin
               rsp_in = '0;
               rsp_in.kind = KIND_READ;
               rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
               if (req_data.read_select == SEL_PPM) begin
                  rsp_in.reading_ppm = ppm_present_ff ? ppm_ff : '0;
                  rsp_in.value_valid = ppm_present_ff;
                  ppm_in = '0;
                  ppm_present_in = 1'b0;
               end else begin
                  rsp_in.percent_hundredths = pct_present_ff ? pct_ff : '0;
                  rsp_in.value_valid = pct_present_ff;
                  pct_in = '0;
                  pct_present_in = 1'b0;
               end
            end
            default: begin
               // unused codes: no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         phase_ff <= 1'b0;
         byte_count_ff <= '0;
         sum_ff <= '0;
         elapsed_ff <= '0;
         ppm_ff <= '0;
         ppm_present_ff <= 1'b0;
         pct_ff <= '0;
         pct_present_ff <= 1'b0;
         send_active_ff <= 1'b0;
         send_idx_ff <= '0;
         send_sel_ff <= REQ_MEASURE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         byte_count_ff <= byte_count_in;
         sum_ff <= sum_in;
         elapsed_ff <= elapsed_in;
         ppm_ff <= ppm_in;
         ppm_present_ff <= ppm_present_in;
         pct_ff <= pct_in;
         pct_present_ff <= pct_present_in;
         send_active_ff <= send_active_in;
         send_idx_ff <= send_idx_in;
         send_sel_ff <= send_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (fb_wr_en) begin
         frame_ff[fb_wr_idx] <= req_data.rx_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_send_has_result: assert property (@(posedge clock) disable iff (reset)
      send_active_ff |-> rsp_valid_ff)
      else $error("frame sender active without a pending result");

   a_send_blocks_input: assert property (@(posedge clock) disable iff (reset)
      send_active_ff && (send_idx_ff != LAST_IDX) |-> !req_ready)
      else $error("input taken in the middle of a request frame");

   a_tx_byte_from_sender: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.kind == KIND_TX_BYTE) |->
         send_active_ff && (rsp_ff.last == (send_idx_ff == LAST_IDX)))
      else $error("byte-to-send result out of step with the frame sender");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !phase_ff |-> (byte_count_ff == '0) && (sum_ff == '0))
      else $error("collection state left over while no reply is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= LAST_IDX)
      else $error("reply byte count past the frame length");
`endif

endmodule
